// ===== hdl/rlt_pkg.sv =====
package rlt_pkg;

	localparam int ACTION_W   = 2;
	localparam int REC_W      = 10;
	localparam int FIELD_TX_W = 16;
	localparam int STATUS_W   = 2;

	localparam logic [ACTION_W-1:0] ACT_ACQUIRE    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RELEASE_TX = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	typedef struct packed {
		logic in_ready;
		logic load_in;
		logic rd_port;
		logic rd_walk;
		logic ctr_clr;
		logic ctr_inc;
		logic wr_clear;
		logic eval_item;
		logic walk_done;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_walk;
		logic slot_free;
		logic ctr_last;
	} dp_sts_t;

endpackage

// ===== hdl/rlt_req_if.sv =====
interface rlt_req_if;
	import rlt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [REC_W-1:0]      record_id;
	logic                  want_exclusive;
	logic [FIELD_TX_W-1:0] tx_id;

	modport source (output valid, action, record_id, want_exclusive, tx_id, input ready);
	modport sink (input valid, action, record_id, want_exclusive, tx_id, output ready);
endinterface

// ===== hdl/rlt_rsp_if.sv =====
interface rlt_rsp_if;
	import rlt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [FIELD_TX_W-1:0] holder_tx;
	logic                  holder_exclusive;

	modport source (output valid, status, holder_tx, holder_exclusive, input ready);
	modport sink (input valid, status, holder_tx, holder_exclusive, output ready);
endinterface

// ===== hdl/rlt_ram.sv =====
module rlt_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/rlt_ctl.sv =====
module rlt_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  rlt_pkg::dp_sts_t sts,
	output rlt_pkg::ctl_cmd_t cmd
);
	import rlt_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_WDONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.wr_clear = 1'b1;
				if (sts.ctr_last) begin
					cmd.ctr_clr = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.ctr_inc = 1'b1;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load_in = 1'b1;
					cmd.rd_port = 1'b1;
					state_d     = sts.in_walk ? S_WALK : S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.slot_free) begin
					cmd.eval_item = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.rd_walk = 1'b1;
				if (sts.ctr_last) begin
					cmd.ctr_clr = 1'b1;
					state_d     = S_WDONE;
				end else begin
					cmd.ctr_inc = 1'b1;
				end
			end
			S_WDONE: begin
				if (sts.slot_free) begin
					cmd.walk_done = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval_item || cmd.walk_done) |-> sts.slot_free)
		else $error("result loaded into a full output slot");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.in_ready && sts.in_valid) |=> !cmd.in_ready)
		else $error("transfer accepted while previous item in flight");

	a_sweep_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR && !sts.ctr_last) |=> state_q == S_CLR)
		else $error("clearing pass left early");

endmodule

// ===== hdl/rlt_dp.sv =====
module rlt_dp #(
	parameter int NUM_RECORDS = 256,
	parameter int TX_BITS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rlt_pkg::ctl_cmd_t cmd,
	output rlt_pkg::dp_sts_t  sts,
	rlt_req_if.sink           req,
	rlt_rsp_if.source         rsp
);
	import rlt_pkg::*;

	localparam int AW    = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
	localparam int ENT_W = TX_BITS + 2;
	localparam logic [REC_W:0]  REC_LIMIT = (REC_W + 1)'(NUM_RECORDS);
	localparam logic [AW-1:0]   LAST_ADDR = AW'(NUM_RECORDS - 1);

	logic [ACTION_W-1:0] action_q;
	logic [REC_W-1:0]    rec_q;
	logic                want_q;
	logic [TX_BITS-1:0]  tx_q;
	logic [AW-1:0]       ctr_q;
	logic                chk_s1;
	logic [AW-1:0]       chk_addr_s1;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [FIELD_TX_W-1:0] holder_tx_q;
	logic                holder_x_q;

	logic [TX_BITS+FIELD_TX_W-1:0] tx_wide;
	logic [TX_BITS+FIELD_TX_W-1:0] hold_wide;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ENT_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [ENT_W-1:0] ram_rdata;

	logic               rd_locked;
	logic               rd_excl;
	logic [TX_BITS-1:0] rd_owner;
	logic               in_range;

	logic [STATUS_W-1:0] it_status;
	logic [TX_BITS-1:0]  it_owner;
	logic                it_excl;
	logic                it_we;
	logic [ENT_W-1:0]    it_wdata;
	logic                walk_hit;
	logic                accept;

	assign accept    = cmd.load_in;
	assign req.ready = cmd.in_ready;

	assign sts.in_valid  = req.valid;
	assign sts.in_walk   = (req.action == ACT_RELEASE_TX);
	assign sts.slot_free = !out_valid_q || rsp.ready;
	assign sts.ctr_last  = (ctr_q == LAST_ADDR);

	assign tx_wide = {{TX_BITS{1'b0}}, req.tx_id};

	assign rd_locked = ram_rdata[ENT_W-1];
	assign rd_excl   = ram_rdata[ENT_W-2];
	assign rd_owner  = ram_rdata[TX_BITS-1:0];
	assign in_range  = ({1'b0, rec_q} < REC_LIMIT);
	assign walk_hit  = chk_s1 && (rd_owner == tx_q);

	always_comb begin
		it_status = ST_OK;
		it_owner  = '0;
		it_excl   = 1'b0;
		it_we     = 1'b0;
		it_wdata  = '0;
		case (action_q)
			ACT_ACQUIRE: begin
				if (!in_range) begin
					it_status = ST_RANGE;
				end else if (!rd_locked) begin
					it_we    = 1'b1;
					it_wdata = {1'b1, want_q, tx_q};
				end else if (rd_owner == tx_q) begin
					if (want_q) begin
						it_we    = 1'b1;
						it_wdata = {1'b1, 1'b1, rd_owner};
					end
				end else if (!rd_excl && !want_q) begin
					it_status = ST_OK;
				end else begin
					it_status = ST_CONFLICT;
					it_owner  = rd_owner;
					it_excl   = rd_excl;
				end
			end
			ACT_RELEASE: begin
				if (!in_range) begin
					it_status = ST_RANGE;
				end else begin
					it_we = 1'b1;
				end
			end
			default: begin
				it_status = ST_OK;
			end
		endcase
	end

	assign hold_wide = {{FIELD_TX_W{1'b0}}, it_owner};

	assign ram_re    = cmd.rd_port || cmd.rd_walk;
	assign ram_raddr = cmd.rd_walk ? ctr_q : req.record_id[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ctr_q;
		ram_wdata = '0;
		if (cmd.wr_clear) begin
			ram_we = 1'b1;
		end else if (cmd.eval_item) begin
			ram_we    = it_we;
			ram_waddr = rec_q[AW-1:0];
			ram_wdata = it_wdata;
		end else if (walk_hit) begin
			ram_we    = 1'b1;
			ram_waddr = chk_addr_s1;
		end
	end

	rlt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_RECORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			rec_q    <= req.record_id;
			want_q   <= req.want_exclusive;
			tx_q     <= tx_wide[TX_BITS-1:0];
		end
		chk_addr_s1 <= ctr_q;
		if (cmd.eval_item) begin
			status_q    <= it_status;
			holder_tx_q <= hold_wide[FIELD_TX_W-1:0];
			holder_x_q  <= it_excl;
		end else if (cmd.walk_done) begin
			status_q    <= ST_OK;
			holder_tx_q <= '0;
			holder_x_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q       <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ctr_clr) begin
				ctr_q <= '0;
			end else if (cmd.ctr_inc) begin
				ctr_q <= ctr_q + 1'b1;
			end
			chk_s1 <= cmd.rd_walk;
			if (cmd.eval_item || cmd.walk_done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = status_q;
	assign rsp.holder_tx        = holder_tx_q;
	assign rsp.holder_exclusive = holder_x_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("table read and write at the same entry");

	a_res_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval_item || cmd.walk_done) |=> rsp.valid)
		else $error("result not presented");

	a_holder_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_CONFLICT) |->
		(rsp.holder_tx == '0 && !rsp.holder_exclusive))
		else $error("holder reported without conflict");

endmodule

// ===== hdl/record_lock_table.sv =====
// Shared/exclusive lock table, one entry per record (locked, mode, owner),
// kept in a single-port-read, single-port-write RAM with registered read.
// After reset the block sweeps the table clear, one entry a cycle; no
// request transfer is taken until that finishes. Acquire and release
// are a read-modify-write of one entry. Release-transaction walks every
// entry through the same RAM ports. One request is in work at a time;
// the response sits in an output register, so a new request is taken while
// the previous response waits. tx_id is used modulo 2^TX_BITS and the
// reported holder is the stored owner zero-extended or cut to 16 bits.
module record_lock_table #(
	parameter int NUM_RECORDS = 256,
	parameter int TX_BITS     = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rlt_req_if.sink   req,
	rlt_rsp_if.source rsp
);
	import rlt_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	rlt_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	rlt_dp #(
		.NUM_RECORDS (NUM_RECORDS),
		.TX_BITS     (TX_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import rlt_pkg::*;

	localparam int TABLE_SIZE = 256;
	localparam int TXN_BITS   = 16;
	localparam int HOLD_CYCLES = 300;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [REC_W-1:0]      record_id;
		logic                  want_exclusive;
		logic [FIELD_TX_W-1:0] tx_id;
	} lock_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [FIELD_TX_W-1:0] holder_tx;
		logic                  holder_exclusive;
	} lock_rsp_t;

	logic clk;
	logic arst_n;

	rlt_req_if req_ch();
	rlt_rsp_if rsp_ch();

	record_lock_table #(
		.NUM_RECORDS(TABLE_SIZE),
		.TX_BITS(TXN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow of the lock table
	bit                    shadow_locked [TABLE_SIZE];
	bit                    shadow_excl   [TABLE_SIZE];
	logic [FIELD_TX_W-1:0] shadow_owner  [TABLE_SIZE];

	lock_req_t req_backlog[$];
	lock_rsp_t expected_rsp[$];

	int  faults = 0;
	int  requests_taken = 0;
	int  results_seen = 0;
	bit  req_taken = 1'b0;
	bit  rsp_taken = 1'b0;
	bit  offering = 1'b0;
	int  send_gap = 0;
	bit  send_calm = 1'b0;
	int  recv_wait = 0;
	bit  recv_calm = 1'b0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	function automatic lock_rsp_t lock_table_apply(lock_req_t r);
		lock_rsp_t o;
		int        rec;
		o = '0;
		rec = int'(r.record_id);
		case (r.action)
			ACT_ACQUIRE: begin
				if (rec >= TABLE_SIZE) begin
					o.status = ST_RANGE;
				end else if (!shadow_locked[rec]) begin
					shadow_locked[rec] = 1'b1;
					shadow_excl[rec]   = r.want_exclusive;
					shadow_owner[rec]  = r.tx_id;
				end else if (shadow_owner[rec] == r.tx_id) begin
					if (r.want_exclusive)
						shadow_excl[rec] = 1'b1;
				end else if (!shadow_excl[rec] && !r.want_exclusive) begin
					// shared on shared: granted, holder unchanged
				end else begin
					o.status           = ST_CONFLICT;
					o.holder_tx        = shadow_owner[rec];
					o.holder_exclusive = shadow_excl[rec];
				end
			end
			ACT_RELEASE: begin
				if (rec >= TABLE_SIZE) begin
					o.status = ST_RANGE;
				end else begin
					shadow_locked[rec] = 1'b0;
					shadow_excl[rec]   = 1'b0;
					shadow_owner[rec]  = '0;
				end
			end
			ACT_RELEASE_TX: begin
				for (int i = 0; i < TABLE_SIZE; i++) begin
					if (shadow_owner[i] == r.tx_id) begin
						shadow_locked[i] = 1'b0;
						shadow_excl[i]   = 1'b0;
						shadow_owner[i]  = '0;
					end
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	task automatic queue_req(input logic [ACTION_W-1:0] action, input logic [REC_W-1:0] rec,
			input logic wx, input logic [FIELD_TX_W-1:0] tx);
		lock_req_t r;
		r.action         = action;
		r.record_id      = rec;
		r.want_exclusive = wx;
		r.tx_id          = tx;
		req_backlog.push_back(r);
	endtask

	task automatic flag_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sender
	always @(negedge clk) begin : sender
		lock_req_t cur;
		if (arst_n) begin
			if (req_taken) begin
				offering = 1'b0;
				if ($urandom_range(0, 99) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 9);
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (req_backlog.size() > 0) begin
					cur = req_backlog.pop_front();
					offering = 1'b1;
					req_ch.action         <= cur.action;
					req_ch.record_id      <= cur.record_id;
					req_ch.want_exclusive <= cur.want_exclusive;
					req_ch.tx_id          <= cur.tx_id;
				end
			end
			req_ch.valid <= offering;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken) begin
				if ($urandom_range(0, 99) == 0)
					recv_calm = !recv_calm;
				recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			rsp_ch.ready <= (recv_wait == 0) && (hold_left == 0);
		end
	end

	// one long receiver hold-off so the block backs up into the request side
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && requests_taken >= 400) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// monitor: check results, then predict for the accepted request
	always @(posedge clk) begin : monitor
		lock_rsp_t got;
		lock_rsp_t want;
		lock_req_t taken;
		if (arst_n) begin
			rsp_taken = rsp_ch.valid && rsp_ch.ready;
			if (rsp_taken) begin
				got.status           = rsp_ch.status;
				got.holder_tx        = rsp_ch.holder_tx;
				got.holder_exclusive = rsp_ch.holder_exclusive;
				if (expected_rsp.size() == 0) begin
					flag_fault($sformatf("unexpected result: status %0d holder %h excl %b",
						got.status, got.holder_tx, got.holder_exclusive));
				end else begin
					want = expected_rsp.pop_front();
					if (got.status !== want.status || got.holder_tx !== want.holder_tx ||
							got.holder_exclusive !== want.holder_exclusive)
						flag_fault($sformatf(
							"result %0d: expected status %0d holder %h excl %b, got status %0d holder %h excl %b",
							results_seen, want.status, want.holder_tx, want.holder_exclusive,
							got.status, got.holder_tx, got.holder_exclusive));
				end
				results_seen++;
			end
			req_taken = req_ch.valid && req_ch.ready;
			if (req_taken) begin
				taken.action         = req_ch.action;
				taken.record_id      = req_ch.record_id;
				taken.want_exclusive = req_ch.want_exclusive;
				taken.tx_id          = req_ch.tx_id;
				expected_rsp.push_back(lock_table_apply(taken));
				requests_taken <= requests_taken + 1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int                    pick;
		logic [REC_W-1:0]      rec;
		logic [FIELD_TX_W-1:0] tx;
		logic                  wx;

		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_ACQUIRE;
		req_ch.record_id = '0;
		req_ch.want_exclusive = 1'b0;
		req_ch.tx_id = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			shadow_locked[i] = 1'b0;
			shadow_excl[i]   = 1'b0;
			shadow_owner[i]  = '0;
		end

		// directed
		queue_req(ACT_ACQUIRE,    10'd256,  1'b0, 16'd5);
		queue_req(ACT_ACQUIRE,    10'd1023, 1'b1, 16'hFFFF);
		queue_req(ACT_RELEASE,    10'd1023, 1'b0, 16'd1);
		queue_req(ACT_UNUSED,     10'h2AA,  1'b1, 16'hA5A5);
		queue_req(ACT_ACQUIRE,    10'd0,    1'b0, 16'd1);
		queue_req(ACT_ACQUIRE,    10'd0,    1'b0, 16'd2);
		queue_req(ACT_ACQUIRE,    10'd0,    1'b1, 16'd2);
		queue_req(ACT_ACQUIRE,    10'd0,    1'b1, 16'd1);
		queue_req(ACT_ACQUIRE,    10'd0,    1'b0, 16'd3);
		queue_req(ACT_ACQUIRE,    10'd255,  1'b1, 16'hFFFF);
		queue_req(ACT_ACQUIRE,    10'd255,  1'b0, 16'hFFFF);
		queue_req(ACT_ACQUIRE,    10'd255,  1'b0, 16'h8000);
		queue_req(ACT_ACQUIRE,    10'd7,    1'b0, 16'd0);
		queue_req(ACT_ACQUIRE,    10'd7,    1'b1, 16'd9);
		queue_req(ACT_RELEASE,    10'd200,  1'b1, 16'd4);
		queue_req(ACT_RELEASE_TX, 10'd1023, 1'b1, 16'd1);
		queue_req(ACT_ACQUIRE,    10'd0,    1'b1, 16'd3);
		queue_req(ACT_RELEASE_TX, 10'd0,    1'b0, 16'd0);
		queue_req(ACT_ACQUIRE,    10'd7,    1'b1, 16'd9);
		queue_req(ACT_RELEASE,    10'd255,  1'b0, 16'd0);
		queue_req(ACT_ACQUIRE,    10'd255,  1'b0, 16'h1234);
		queue_req(ACT_RELEASE_TX, 10'd511,  1'b0, 16'hFFFF);
		queue_req(ACT_RELEASE,    10'd0,    1'b0, 16'd3);

		// random: contention on a few hot records from a small pool of transactions
		for (int n = 0; n < 1500; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0)
				rec = REC_W'($urandom_range(0, TABLE_SIZE - 1));
			else
				rec = REC_W'($urandom_range(0, 15) + ($urandom_range(0, 1) ? 240 : 0));
			tx = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
			wx = 1'($urandom_range(0, 1));
			if (pick < 55)
				queue_req(ACT_ACQUIRE, rec, wx, tx);
			else if (pick < 78)
				queue_req(ACT_RELEASE, rec, wx, tx);
			else if (pick < 83)
				queue_req(ACT_RELEASE_TX, REC_W'($urandom_range(0, 1023)), wx, tx);
			else if (pick < 93)
				queue_req((pick % 2) ? ACT_ACQUIRE : ACT_RELEASE,
					REC_W'($urandom_range(0, 1023)), wx,
					FIELD_TX_W'($urandom_range(0, 65535)));
			else if (pick < 97)
				queue_req(ACT_ACQUIRE, rec, wx, FIELD_TX_W'($urandom_range(0, 65535)));
			else
				queue_req(ACT_UNUSED, REC_W'($urandom_range(0, 1023)), wx,
					FIELD_TX_W'($urandom_range(0, 65535)));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || offering || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (TABLE_SIZE + 20) @(posedge clk);

		if (expected_rsp.size() != 0)
			flag_fault($sformatf("%0d results never arrived", expected_rsp.size()));

		if (faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
